### design/swprm_pkg.sv
// Shared constants, register indexes and controller states for the
// sliding-window pulse rate meter. No dependencies.
package swprm_pkg;

  localparam int DEPTH     = 128;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int RATE_W    = 40;
  localparam int FRAC_W    = 8;
  localparam int NUM_W     = TIME_W + CNT_W;
  localparam int PROD_W    = PTR_W + CFG_W;
  localparam int DIV_CNT_W = $clog2(RATE_W);
  localparam int IN_W      = 64;
  localparam int OUT_W     = 104;

  localparam logic [CNT_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [CFG_W-1:0] PERIOD_RESET  = 16'd160;
  localparam logic [CFG_W-1:0] UNIT_RESET    = 16'd6000;

  localparam logic CFG_PROCESS_PERIOD = 1'b0;
  localparam logic CFG_HISTORY_UNIT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD,
    ST_SUB,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_DIV
  } state_t;

endpackage

### design/swprm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module swprm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sliding_window_pulse_rate_meter_top.sv
// Sliding-window pulse rate meter: slot ring in RAM, running total,
// integration time and a bit-serial divider for counts per minute.
// Depends on swprm_pkg and swprm_ram.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One beat in, one beat out. Per item the controller checks the process period,
// adds a noise-free sample to the current slot and the running total, drops the
// oldest slot on a slot crossing, forms the integration time and scaled count and
// runs the radix-2 divider unless the time is zero or the rate saturates. Input is
// taken only when the controller is idle; a result waiting on m_tready keeps the
// controller idle and blocks the next input beat. Reset (rst, synchronous) clears
// control state, loads default period and unit; slot valid bits clear the ring.
module sliding_window_pulse_rate_meter_top
  import swprm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // now_ms, signal_count, noise_count
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // window_count, integration_ms, rate_cpm_q8
  output logic             m_tuser,   // processed
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CFG_W-1:0]     period;
  logic [CFG_W-1:0]     unit;
  logic [TIME_W-1:0]    last_process_time;
  logic [TIME_W-1:0]    last_slot_time;
  logic [TIME_W-1:0]    running_total;
  logic [PTR_W-1:0]     slot_pointer;
  logic [PTR_W-1:0]     filled_slots;
  logic [DEPTH-1:0]     slot_valid;

  logic [TIME_W-1:0]    now;
  logic [CNT_W-1:0]     sig;
  logic [CNT_W-1:0]     noise;
  logic                 processed;
  logic                 slot_cross;
  logic [PROD_W-1:0]    prod;
  logic [TIME_W-1:0]    tdiff;
  logic [NUM_W-1:0]     num;
  logic [TIME_W-1:0]    ms;
  logic [TIME_W-1:0]    rem;
  logic [RATE_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 fin_hold;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_raddr;
  logic [TIME_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]    slot_old;
  logic [TIME_W-1:0]    slot_sum;
  logic [PTR_W-1:0]     ptr_inc;
  logic                 period_ok;
  logic                 cross_now;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W+1:0]    rem_diff;
  logic                 out_free;
  logic                 div_last;

  assign s_tready  = !rst && (state == ST_IDLE) && !fin_hold;
  assign out_free  = !m_tvalid || m_tready;
  assign period_ok = (now - last_process_time) >= {{(TIME_W-CFG_W){1'b0}}, period};
  assign cross_now = (now - last_slot_time) >= {{(TIME_W-CFG_W){1'b0}}, unit};
  assign ptr_inc   = (slot_pointer == PTR_W'(DEPTH-1)) ? '0 : slot_pointer + 1'b1;
  assign slot_old  = slot_valid[slot_pointer] ? ram_rdata : '0;
  assign slot_sum  = slot_old + {{(TIME_W-CNT_W){1'b0}}, sig};
  assign rem_sh    = {rem, quo[RATE_W-1]};
  assign rem_diff  = {1'b0, rem_sh} - {2'b00, ms};
  assign div_last  = (div_cnt == DIV_CNT_W'(RATE_W-1));

  swprm_ram #(
    .WIDTH(TIME_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_pointer),
    .wdata(slot_sum),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_raddr  = slot_pointer;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = period_ok ? ST_ADD : ST_MUL;
      end
      ST_ADD: begin
        ram_we     = (noise == '0);
        ram_raddr  = ptr_inc;
        state_next = slot_cross ? ST_SUB : ST_MUL;
      end
      ST_SUB: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_PREP;
      end
      ST_PREP: begin
        if ((ms == '0) || ({{(TIME_W-CNT_W){1'b0}}, num[NUM_W-1 -: CNT_W]} >= ms)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      period            <= PERIOD_RESET;
      unit              <= UNIT_RESET;
      last_process_time <= '0;
      last_slot_time    <= '0;
      running_total     <= '0;
      slot_pointer      <= '0;
      filled_slots      <= '0;
      slot_valid        <= '0;
      m_tvalid          <= 1'b0;
      fin_hold          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROCESS_PERIOD: period <= cfg_data;
          CFG_HISTORY_UNIT:   unit   <= cfg_data;
        endcase
      end
      unique case (state)
        ST_ADD: begin
          if (noise == '0) begin
            running_total            <= running_total + {{(TIME_W-CNT_W){1'b0}}, sig};
            slot_valid[slot_pointer] <= 1'b1;
          end
          if (slot_cross) begin
            last_slot_time <= last_slot_time + {{(TIME_W-CFG_W){1'b0}}, unit};
            slot_pointer   <= ptr_inc;
            if (filled_slots != PTR_W'(DEPTH-1)) begin
              filled_slots <= filled_slots + 1'b1;
            end
          end
          last_process_time <= now;
        end
        ST_SUB: begin
          running_total            <= running_total - slot_old;
          slot_valid[slot_pointer] <= 1'b0;
        end
        default: begin
        end
      endcase
      // finished result waits here until the output register is free
      if ((state_next == ST_IDLE) && (state != ST_IDLE)) begin
        fin_hold <= 1'b1;
      end
      if (fin_hold && out_free) begin
        m_tvalid <= 1'b1;
        fin_hold <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          now   <= s_tdata[TIME_W-1:0];
          sig   <= s_tdata[TIME_W +: CNT_W];
          noise <= s_tdata[TIME_W+CNT_W +: CNT_W];
        end
      end
      ST_CHECK: begin
        processed  <= period_ok;
        slot_cross <= cross_now;
      end
      ST_MUL: begin
        prod  <= PROD_W'(filled_slots) * PROD_W'(unit);
        tdiff <= last_process_time - last_slot_time;
        num   <= NUM_W'(running_total) * NUM_W'(MS_PER_MINUTE);
      end
      ST_SUM: begin
        ms <= {{(TIME_W-PROD_W){1'b0}}, prod} + tdiff;
      end
      ST_PREP: begin
        rem     <= {{(TIME_W-CNT_W){1'b0}}, num[NUM_W-1 -: CNT_W]};
        div_cnt <= '0;
        if (ms == '0) begin
          quo <= '0;
        end else if ({{(TIME_W-CNT_W){1'b0}}, num[NUM_W-1 -: CNT_W]} >= ms) begin
          quo <= '1;
        end else begin
          quo <= {num[NUM_W-CNT_W-1:0], {FRAC_W{1'b0}}};
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (!rem_diff[TIME_W+1]) begin
          rem <= rem_diff[TIME_W-1:0];
          quo <= {quo[RATE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[TIME_W-1:0];
          quo <= {quo[RATE_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (fin_hold && out_free) begin
      m_tdata <= {quo, ms, running_total};
      m_tuser <= processed;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < ms)
    else $error("divider remainder not below divisor");

  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[63:32] == '0) |-> m_tdata[103:64] == '0)
    else $error("nonzero rate with zero integration time");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    (filled_slots <= PTR_W'(DEPTH-1)) && (slot_pointer <= PTR_W'(DEPTH-1)))
    else $error("ring pointer or fill count out of range");

endmodule
